// ===== design/cbba_pkg.sv =====
package cbba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int ROW_BITS   = 32;
    localparam int NROWS      = MAX_BLOCKS / ROW_BITS;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int COL_W      = $clog2(ROW_BITS);
    localparam int ROW_W      = IDX_W - COL_W;
    localparam int LIM_W      = IDX_W + 1;

    localparam int OPC_W  = 2;
    localparam int START_W = 10;
    localparam int SIZE_W = 23;
    localparam int BB_W   = 13;
    localparam int BIU_W  = 11;
    localparam int ABLK_W = 10;
    localparam int DIVD_W = SIZE_W + 1;
    localparam int EXT_W  = DIVD_W;
    localparam int SUM_W  = EXT_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BB_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

    localparam logic [BB_W-1:0]  BB_RESET  = 13'd64;
    localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

    localparam logic [OPC_W-1:0] OP_CREATE   = 2'd0;
    localparam logic [OPC_W-1:0] OP_DELETE   = 2'd1;
    localparam logic [OPC_W-1:0] OP_TRUNCATE = 2'd2;

    typedef enum logic [1:0] {
        RK_CREATE,
        RK_CLEAR,
        RK_CHECK,
        RK_SET
    } t_kind;

    typedef enum logic [1:0] {
        PL_CREATE,
        PL_DELETE,
        PL_SHRINK,
        PL_GROW
    } t_plan;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_DIV_CUR,
        ST_DIV_NEW,
        ST_PLAN,
        ST_RD,
        ST_MOD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  load;
        logic  init_wr;
        logic  div_start;
        logic  div_sel_new;
        logic  save_old;
        logic  save_new;
        logic  setup;
        t_plan plan;
        logic  restart;
        logic  rd;
        logic  modify;
        logic  next;
        logic  fail;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic             init_last;
        logic [OPC_W-1:0] op;
        logic             div_done;
        logic             nsz_gt;
        logic             grow_blk;
        logic             shrink_blk;
        logic             grow_fits;
        logic             empty;
        t_kind            kind;
        logic             hit;
        logic             last_row;
        logic             out_free;
    } t_stat;

endpackage

// ===== design/cbba_div.sv =====
module cbba_div
    import cbba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [BB_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [BB_W-1:0]   r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [BB_W-1:0]   r_dvs;

    logic [BB_W:0] rem_sh;
    logic [BB_W:0] diff;

    assign rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[BB_W]) begin
                r_rem <= diff[BB_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[BB_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== design/cbba_datapath.sv =====
module cbba_datapath
    import cbba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [OPC_W-1:0]      i_opcode,
    input  logic [START_W-1:0]    i_start_block,
    input  logic [SIZE_W-1:0]     i_current_size,
    input  logic [SIZE_W-1:0]     i_new_size,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic                  o_status,
    output logic [ABLK_W-1:0]     o_allocated_block
);

    logic [BB_W-1:0]     r_bb;
    logic [BIU_W-1:0]    r_biu;
    logic [OPC_W-1:0]    r_op;
    logic [START_W-1:0]  r_start;
    logic [SIZE_W-1:0]   r_cur;
    logic [SIZE_W-1:0]   r_nsz;
    logic [EXT_W-1:0]    r_oldb;
    logic [EXT_W-1:0]    r_newb;
    logic [IDX_W-1:0]    r_from;
    logic [IDX_W-1:0]    r_tlast;
    logic                r_empty;
    t_kind               r_kind;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_BITS-1:0] r_rdata;
    logic [ROW_BITS-1:0] r_map [NROWS];
    logic                r_status;
    logic [IDX_W-1:0]    r_blk;
    logic                r_mvalid;
    logic                r_mstatus;
    logic [IDX_W-1:0]    r_mblk;

    logic [LIM_W-1:0]    lim;
    logic [BB_W-1:0]     bb_eff;
    logic [SIZE_W-1:0]   size_sel;
    logic [DIVD_W-1:0]   dividend;
    logic                div_done;
    logic [DIVD_W-1:0]   quot;
    logic [EXT_W-1:0]    ext;
    logic [SUM_W-1:0]    s_old;
    logic [SUM_W-1:0]    s_new;
    logic [SUM_W-1:0]    f_full;
    logic [SUM_W-1:0]    t_full;
    logic [LIM_W-1:0]    t_c;
    logic [LIM_W-1:0]    t_c_m1;
    logic                set_empty;
    t_kind               set_kind;
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] free_bits;
    logic [ROW_BITS-1:0] first_free;
    logic [COL_W-1:0]    free_idx;
    logic                hit;
    logic                wr_en;
    logic [ROW_BITS-1:0] wr_data;
    logic                out_free;

    assign lim = (r_biu > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : LIM_W'(r_biu);
    assign bb_eff   = (r_bb == '0) ? BB_W'(1) : r_bb;
    assign size_sel = i_cmd.div_sel_new ? r_nsz : r_cur;
    assign dividend = {1'b0, size_sel} + DIVD_W'(bb_eff) - DIVD_W'(1);
    assign ext      = (quot == '0) ? EXT_W'(1) : quot;

    cbba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (bb_eff),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign s_old = SUM_W'(r_start) + SUM_W'(r_oldb);
    assign s_new = SUM_W'(r_start) + SUM_W'(r_newb);

    // range of blocks touched by the operation, clipped to the managed range
    always_comb begin
        unique case (i_cmd.plan)
            PL_CREATE: begin
                f_full   = '0;
                t_full   = SUM_W'(lim);
                set_kind = RK_CREATE;
            end
            PL_DELETE: begin
                f_full   = SUM_W'(r_start);
                t_full   = s_old;
                set_kind = RK_CLEAR;
            end
            PL_SHRINK: begin
                f_full   = s_new;
                t_full   = s_old;
                set_kind = RK_CLEAR;
            end
            PL_GROW: begin
                f_full   = s_old;
                t_full   = s_new;
                set_kind = RK_CHECK;
            end
            default: begin
                f_full   = '0;
                t_full   = '0;
                set_kind = RK_CREATE;
            end
        endcase
        t_c       = (t_full > SUM_W'(lim)) ? lim : t_full[LIM_W-1:0];
        t_c_m1    = t_c - LIM_W'(1);
        set_empty = (f_full >= SUM_W'(t_c));
    end

    always_comb begin
        for (int i = 0; i < ROW_BITS; i++) begin
            mask[i] = ({r_row, COL_W'(i)} >= r_from) && ({r_row, COL_W'(i)} <= r_tlast);
        end
        free_bits = ~r_rdata & mask;
        free_idx  = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = COL_W'(i);
            end
        end
        first_free = ROW_BITS'(1) << free_idx;
    end

    always_comb begin
        unique case (r_kind)
            RK_CREATE: hit = |free_bits;
            RK_CHECK:  hit = |(r_rdata & mask);
            default:   hit = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = '0;
        if (i_cmd.init_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.modify) begin
            unique case (r_kind)
                RK_CREATE: begin
                    wr_en   = hit;
                    wr_data = r_rdata | first_free;
                end
                RK_CLEAR: begin
                    wr_en   = 1'b1;
                    wr_data = r_rdata & ~mask;
                end
                RK_SET: begin
                    wr_en   = 1'b1;
                    wr_data = r_rdata | mask;
                end
                default: begin
                    wr_en   = 1'b0;
                    wr_data = r_rdata;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[r_row] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_map[r_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bb  <= BB_RESET;
            r_biu <= BIU_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_BYTES:   r_bb  <= i_cfg_data[BB_W-1:0];
                CFG_BLOCKS_IN_USE: r_biu <= i_cfg_data[BIU_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_cmd.setup) begin
            r_row <= f_full[IDX_W-1:COL_W];
        end else if (i_cmd.restart) begin
            r_row <= r_from[IDX_W-1:COL_W];
        end else if (i_cmd.init_wr || i_cmd.next) begin
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_start <= i_start_block;
            r_cur   <= i_current_size;
            r_nsz   <= i_new_size;
        end
        if (i_cmd.save_old) begin
            r_oldb <= ext;
        end
        if (i_cmd.save_new) begin
            r_newb <= ext;
        end
        if (i_cmd.setup) begin
            r_from  <= f_full[IDX_W-1:0];
            r_tlast <= t_c_m1[IDX_W-1:0];
            r_empty <= set_empty;
            r_kind  <= set_kind;
        end else if (i_cmd.restart) begin
            r_kind <= RK_SET;
        end
        if (i_cmd.load) begin
            r_status <= 1'b0;
            r_blk    <= '0;
        end else begin
            if (i_cmd.fail) begin
                r_status <= 1'b1;
            end
            if (i_cmd.modify && r_kind == RK_CREATE && hit) begin
                r_blk <= {r_row, free_idx};
            end
        end
    end

    assign out_free = !r_mvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_mvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mstatus <= r_status;
            r_mblk    <= r_blk;
        end
    end

    assign o_m_tvalid        = r_mvalid;
    assign o_status          = r_mstatus;
    assign o_allocated_block = ABLK_W'(r_mblk);

    always_comb begin
        o_stat            = '0;
        o_stat.init_last  = (r_row == ROW_W'(NROWS - 1));
        o_stat.op         = r_op;
        o_stat.div_done   = div_done;
        o_stat.nsz_gt     = (r_nsz > r_cur);
        o_stat.grow_blk   = (r_newb > r_oldb);
        o_stat.shrink_blk = (r_oldb > r_newb);
        o_stat.grow_fits  = (s_new <= SUM_W'(lim));
        o_stat.empty      = r_empty;
        o_stat.kind       = r_kind;
        o_stat.hit        = hit;
        o_stat.last_row   = (r_row == r_tlast[IDX_W-1:COL_W]);
        o_stat.out_free   = out_free;
    end

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result loaded into a full output register");

    a_no_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> !r_empty)
        else $error("row read for an empty range");

    a_save_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.save_old || i_cmd.save_new) |-> div_done)
        else $error("extent saved before the divider finished");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mvalid) |-> $past(i_cmd.out_load))
        else $error("output valid without a result load");

endmodule

// ===== design/cbba_ctrl.sv =====
module cbba_ctrl
    import cbba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.op == OP_CREATE) begin
                    o_cmd.setup = 1'b1;
                    o_cmd.plan  = PL_CREATE;
                    n_state     = ST_RD;
                end else if (i_stat.op == OP_DELETE || i_stat.op == OP_TRUNCATE) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_CUR;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_DONE;
                end
            end
            ST_DIV_CUR: begin
                if (i_stat.div_done) begin
                    o_cmd.save_old = 1'b1;
                    if (i_stat.op == OP_DELETE) begin
                        n_state = ST_PLAN;
                    end else begin
                        o_cmd.div_start   = 1'b1;
                        o_cmd.div_sel_new = 1'b1;
                        n_state           = ST_DIV_NEW;
                    end
                end
            end
            ST_DIV_NEW: begin
                if (i_stat.div_done) begin
                    o_cmd.save_new = 1'b1;
                    n_state        = ST_PLAN;
                end
            end
            ST_PLAN: begin
                n_state = ST_DONE;
                priority if (i_stat.op == OP_DELETE) begin
                    o_cmd.setup = 1'b1;
                    o_cmd.plan  = PL_DELETE;
                    n_state     = ST_RD;
                end else if (i_stat.nsz_gt) begin
                    if (i_stat.grow_blk) begin
                        if (i_stat.grow_fits) begin
                            o_cmd.setup = 1'b1;
                            o_cmd.plan  = PL_GROW;
                            n_state     = ST_RD;
                        end else begin
                            o_cmd.fail = 1'b1;
                        end
                    end
                end else if (i_stat.shrink_blk) begin
                    o_cmd.setup = 1'b1;
                    o_cmd.plan  = PL_SHRINK;
                    n_state     = ST_RD;
                end
            end
            ST_RD: begin
                if (i_stat.empty) begin
                    o_cmd.fail = (i_stat.kind == RK_CREATE);
                    n_state    = ST_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_MOD;
                end
            end
            ST_MOD: begin
                o_cmd.modify = 1'b1;
                unique case (i_stat.kind)
                    RK_CREATE: begin
                        if (i_stat.hit) begin
                            n_state = ST_DONE;
                        end else if (i_stat.last_row) begin
                            o_cmd.fail = 1'b1;
                            n_state    = ST_DONE;
                        end else begin
                            o_cmd.next = 1'b1;
                            n_state    = ST_RD;
                        end
                    end
                    RK_CHECK: begin
                        if (i_stat.hit) begin
                            o_cmd.fail = 1'b1;
                            n_state    = ST_DONE;
                        end else if (i_stat.last_row) begin
                            o_cmd.restart = 1'b1;
                            n_state       = ST_RD;
                        end else begin
                            o_cmd.next = 1'b1;
                            n_state    = ST_RD;
                        end
                    end
                    default: begin
                        if (i_stat.last_row) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.next = 1'b1;
                            n_state    = ST_RD;
                        end
                    end
                endcase
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/contiguous_block_bitmap_allocator.sv =====
// Bitmap allocator of contiguous storage blocks. The used/free map sits in a 32 x 32-bit
// memory and is worked one row at a time: read, then modify and write. After reset a
// clearing pass zeroes the map; no request is taken until it ends, configuration writes
// are taken throughout. Create scans the rows up to the first free block. Delete and
// truncate first turn byte sizes into block counts with a shared bit-serial divider (one
// division for delete, two for truncate), then work over each row of the extent touched;
// a grow goes over its rows twice, once to check and once to mark. One request is in work
// at a time; the result register lets the next request in while a result waits.
module contiguous_block_bitmap_allocator
    import cbba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // opcode, start_block, current_size, new_size
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // status, allocated_block
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd              cmd;
    t_stat             stat;
    logic              status;
    logic [ABLK_W-1:0] allocated_block;

    cbba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cbba_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_opcode          (s_axis_tdata[1:0]),
        .i_start_block     (s_axis_tdata[11:2]),
        .i_current_size    (s_axis_tdata[34:12]),
        .i_new_size        (s_axis_tdata[57:35]),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_m_tready        (m_axis_tready),
        .o_m_tvalid        (m_axis_tvalid),
        .o_status          (status),
        .o_allocated_block (allocated_block)
    );

    assign m_axis_tdata = {5'b0, allocated_block, status};

endmodule

// ===== tb/sv/cbba_checker.sv =====
`timescale 1ns / 1ps

module cbba_checker
    import cbba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // opcode, start_block, current_size, new_size
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [15:0]           m_axis_tdata,  // status, allocated_block
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic              failed;
        logic [ABLK_W-1:0] blk;
    } t_alloc_rsp;

    logic [BB_W-1:0]  blk_bytes;
    logic [BIU_W-1:0] blk_count;
    bit               used_map [MAX_BLOCKS];
    t_alloc_rsp       rsp_q [$];
    int               n_errors;

    function automatic int unsigned managed_blocks();
        return (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : blk_count;
    endfunction

    function automatic int unsigned extent_of(int unsigned bytes);
        int unsigned bb;
        int unsigned n;
        bb = (blk_bytes == 0) ? 1 : blk_bytes;
        n  = (bytes + bb - 1) / bb;
        return (n == 0) ? 1 : n;
    endfunction

    // blocks at or past the managed range are left alone
    function automatic void mark_span(int unsigned from, int unsigned to, bit value);
        int unsigned lim;
        int unsigned i;
        lim = managed_blocks();
        if (to > lim) begin
            to = lim;
        end
        for (i = from; i < to; i++) begin
            used_map[i] = value;
        end
    endfunction

    function automatic t_alloc_rsp serve_request(logic [OPC_W-1:0]   op,
                                                 logic [START_W-1:0] start,
                                                 logic [SIZE_W-1:0]  cur,
                                                 logic [SIZE_W-1:0]  nsz);
        t_alloc_rsp  rsp;
        int unsigned lim;
        int unsigned old_n;
        int unsigned new_n;
        int unsigned i;
        bit          room;
        rsp = '0;
        lim = managed_blocks();
        case (op)
            OP_CREATE: begin
                rsp.failed = 1'b1;
                for (i = 0; rsp.failed && i < lim; i++) begin
                    if (!used_map[i]) begin
                        used_map[i] = 1'b1;
                        rsp.blk     = i[ABLK_W-1:0];
                        rsp.failed  = 1'b0;
                    end
                end
            end
            OP_DELETE: begin
                mark_span(start, start + extent_of(cur), 1'b0);
            end
            OP_TRUNCATE: begin
                old_n = extent_of(cur);
                new_n = extent_of(nsz);
                if (nsz > cur) begin
                    if (new_n > old_n) begin
                        room = (start + new_n <= lim);
                        for (i = start + old_n; room && i < start + new_n; i++) begin
                            if (used_map[i]) begin
                                room = 1'b0;
                            end
                        end
                        if (room) begin
                            mark_span(start + old_n, start + new_n, 1'b1);
                        end else begin
                            rsp.failed = 1'b1;
                        end
                    end
                end else if (old_n > new_n) begin
                    mark_span(start + new_n, start + old_n, 1'b0);
                end
            end
            default: begin
                rsp.failed = 1'b1;
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_rsp want;
        t_alloc_rsp got;
        if (!i_rst_n) begin
            blk_bytes = BB_RESET;
            blk_count = BIU_RESET;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                used_map[i] = 1'b0;
            end
            rsp_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_BYTES:   blk_bytes = i_cfg_data[BB_W-1:0];
                    CFG_BLOCKS_IN_USE: blk_count = i_cfg_data[BIU_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rsp_q.push_back(serve_request(
                    s_axis_tdata[OPC_W-1:0],
                    s_axis_tdata[OPC_W +: START_W],
                    s_axis_tdata[OPC_W+START_W +: SIZE_W],
                    s_axis_tdata[OPC_W+START_W+SIZE_W +: SIZE_W]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.failed = m_axis_tdata[0];
                got.blk    = m_axis_tdata[ABLK_W:1];
                if (rsp_q.size() == 0) begin
                    $error("unexpected result transfer: status %0d allocated_block %0d",
                           got.failed, got.blk);
                    n_errors++;
                end else begin
                    want = rsp_q.pop_front();
                    if (got.failed !== want.failed) begin
                        $error("status: expected %0d, got %0d", want.failed, got.failed);
                        n_errors++;
                    end
                    if (got.blk !== want.blk) begin
                        $error("allocated_block: expected %0d, got %0d", want.blk, got.blk);
                        n_errors++;
                    end
                end
            end
        end
        o_errors  <= n_errors;
        o_pending <= rsp_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cbba_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          N_PHASES       = 8;
    localparam int          RAND_PER_PHASE = 210;
    localparam int unsigned MAX_SIZE       = 4194304;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    typedef struct {
        logic [OPC_W-1:0] op;
        int unsigned      start;
        int unsigned      nsz;
    } t_req_note;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;  // opcode, start_block, current_size, new_size
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;        // status, allocated_block
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int          n_errors;
    int          n_pending;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int unsigned cur_bb      = 64;
    t_rx_mode    rx_mode     = RX_OPEN;
    int          rx_hold     = 0;

    int unsigned file_start [$];
    int unsigned file_size  [$];
    t_req_note   note_q     [$];

    int unsigned phase_bb  [N_PHASES] = '{64, 1, 4096, 100, 7, 4096, 0, 33};
    int unsigned phase_biu [N_PHASES] = '{1024, 40, 2047, 1, 300, 2, 1024, 64};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    contiguous_block_bitmap_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    cbba_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (n_errors),
        .o_pending     (n_pending)
    );

    // result side stalls in randomly chosen modes: always ready, coin flip, or sparse
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode = t_rx_mode'($urandom_range(RX_OPEN, RX_SPARSE));
            rx_hold = $urandom_range(50, 300);
        end else begin
            rx_hold--;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            default:   m_axis_tready <= ($urandom_range(0, 19) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // learn created blocks and granted sizes; the transfer lands on the next rising edge
    always @(negedge i_clk) begin
        t_req_note note;
        if (i_rst_n && m_axis_tvalid && m_axis_tready && note_q.size() > 0) begin
            note = note_q.pop_front();
            if (!m_axis_tdata[0]) begin
                if (note.op == OP_CREATE) begin
                    file_start.push_back(int'(m_axis_tdata[ABLK_W:1]));
                    file_size.push_back(0);
                end else if (note.op == OP_TRUNCATE) begin
                    foreach (file_start[k]) begin
                        if (file_start[k] == note.start) begin
                            file_size[k] = note.nsz;
                        end
                    end
                end
            end
        end
    end

    task automatic send(input logic [OPC_W-1:0] op,
                        input int unsigned      start,
                        input int unsigned      cur,
                        input int unsigned      nsz);
        t_req_note note;
        int        gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 64'({SIZE_W'(nsz), SIZE_W'(cur), START_W'(start), op});
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        note.op    = op;
        note.start = start;
        note.nsz   = nsz;
        note_q.push_back(note);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (n_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    function automatic int unsigned pick_size(int unsigned bb);
        int unsigned sz;
        sz = $urandom_range(0, 6) * bb;
        if ($urandom_range(0, 1) == 1) begin
            sz += $urandom_range(1, (bb > 1) ? bb - 1 : 1);
        end
        return (sz > MAX_SIZE) ? MAX_SIZE : sz;
    endfunction

    function automatic int unsigned noise_size(int unsigned bb);
        return ($urandom_range(0, 1) == 1) ? $urandom_range(0, MAX_SIZE)
                                           : $urandom_range(0, 8 * bb);
    endfunction

    task automatic random_request();
        int          r;
        int          k;
        int unsigned s;
        int unsigned sz;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            send(OPC_W'($urandom_range(0, (1 << OPC_W) - 1)), $urandom_range(0, 1023),
                 noise_size(cur_bb), noise_size(cur_bb));
        end else if (r < 47 || file_start.size() == 0) begin
            send(OP_CREATE, $urandom_range(0, 1023), noise_size(cur_bb), noise_size(cur_bb));
        end else begin
            k  = $urandom_range(0, file_start.size() - 1);
            s  = file_start[k];
            sz = file_size[k];
            if (r < 65) begin
                file_start.delete(k);
                file_size.delete(k);
                send(OP_DELETE, s, sz, noise_size(cur_bb));
            end else begin
                send(OP_TRUNCATE, s, sz, pick_size(cur_bb));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset configuration: 64-byte blocks, full map
        send(OP_CREATE,   0,    0,        0);
        send(OP_CREATE,   1023, MAX_SIZE, MAX_SIZE);
        send(OP_CREATE,   0,    0,        0);
        send(OP_DELETE,   1,    0,        0);         // one block for an empty file
        send(OP_CREATE,   0,    0,        0);
        send(OP_TRUNCATE, 2,    0,        192);       // grow into free blocks
        send(OP_TRUNCATE, 0,    0,        128);       // grow blocked by a used block
        send(OP_TRUNCATE, 2,    130,      190);       // larger size, same block count
        send(OP_TRUNCATE, 2,    192,      192);       // same size
        send(OP_TRUNCATE, 2,    192,      0);         // shrink frees the tail
        send(OP_DELETE,   500,  64,       0);         // delete of free blocks
        send(OP_TRUNCATE, 1020, 0,        MAX_SIZE);  // grow past the managed range
        send(OP_TRUNCATE, 1022, 64,       128);       // grow onto the last block
        send(OP_TRUNCATE, 1022, 128,      192);       // grow one past the end
        send(OP_DELETE,   1023, MAX_SIZE, 0);         // delete clipped at the end
        send(OP_DELETE,   0,    MAX_SIZE, MAX_SIZE);  // frees the whole map
        send(OP_CREATE,   0,    0,        0);
        send(OP_TRUNCATE, 0,    MAX_SIZE, 1);
        send(OP_CREATE,   0,    0,        0);
        drain();
        file_start.delete();
        file_size.delete();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                cur_bb = phase_bb[p];
                write_reg(CFG_BLOCK_BYTES, phase_bb[p]);
                write_reg(CFG_BLOCKS_IN_USE, phase_biu[p]);
                i_cfg_we <= 1'b0;
                @(posedge i_clk);
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                random_request();
            end
            drain();
            // release every tracked file so the next phase starts near empty
            while (file_start.size() > 0) begin
                send(OP_DELETE, file_start[0], file_size[0], 0);
                file_start.delete(0);
                file_size.delete(0);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/cbba_pkg.sv
design/cbba_div.sv
design/cbba_datapath.sv
design/cbba_ctrl.sv
design/contiguous_block_bitmap_allocator.sv
tb/sv/cbba_checker.sv
tb/sv/tb_top.sv
